@@ rtl/i2p_pkg.sv @@
// Shared constants and helpers for the infix to postfix converter.
// Symbol classes, error codes and operator precedence; no dependencies.
`timescale 1ns / 1ps

package i2p_pkg;

    // ASCII codes of the operator and bracket symbols
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_MUL   = 8'h2A;
    localparam logic [7:0] C_DIV   = 8'h2F;
    localparam logic [7:0] C_POW   = 8'h5E;
    localparam logic [7:0] C_LPAR  = 8'h28;
    localparam logic [7:0] C_RPAR  = 8'h29;
    localparam logic [7:0] C_NUL   = 8'h00;

    // Error codes carried on result words
    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_INVALID = 2'd1;
    localparam logic [1:0] E_OVERFLOW = 2'd2;
    localparam logic [1:0] E_UNMATCH = 2'd3;

    typedef logic [2:0] t_class;

    // Symbol classes
    localparam t_class CL_LETTER  = 3'd0;
    localparam t_class CL_LPAREN  = 3'd1;
    localparam t_class CL_OPER    = 3'd2;
    localparam t_class CL_RPAREN  = 3'd3;
    localparam t_class CL_ZERO    = 3'd4;
    localparam t_class CL_INVALID = 3'd5;

    // Precedence: 0 for anything that is not an operator
    function automatic logic [1:0] f_prec(input logic [7:0] c);
        case (c) inside
            C_PLUS, C_MINUS: f_prec = 2'd1;
            C_MUL, C_DIV:    f_prec = 2'd2;
            C_POW:           f_prec = 2'd3;
            default:         f_prec = 2'd0;
        endcase
    endfunction

    // Sort an incoming symbol into its class
    function automatic t_class f_class(input logic [7:0] c);
        case (c) inside
            [8'h41:8'h5A], [8'h61:8'h7A]:        f_class = CL_LETTER;
            C_LPAR:                              f_class = CL_LPAREN;
            C_PLUS, C_MINUS, C_MUL, C_DIV, C_POW: f_class = CL_OPER;
            C_RPAR:                              f_class = CL_RPAREN;
            C_NUL:                               f_class = CL_ZERO;
            default:                             f_class = CL_INVALID;
        endcase
    endfunction

endpackage

@@ rtl/i2p_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Stand-alone; used for the operator stack.
`timescale 1ns / 1ps

module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/infix_to_postfix_converter_top.sv @@
// Top level of the infix to postfix converter (shunting-yard sequencer).
// Depends on i2p_pkg and i2p_ram, which holds the operator stack.
`timescale 1ns / 1ps

// Usage:
//   Input channel  i_valid / o_ready carries one ASCII character per word on
//   i_symbol; a zero byte ends the expression. Output channel o_valid /
//   i_ready carries result words: o_out_symbol, o_error_code, o_expr_end and
//   o_last, which marks the final word caused by one input character.
//   Sequencing: an input word is taken in idle, evaluated and then flushed;
//   each pop that does not finish the character adds an evaluation step and a
//   wait state for the registered RAM read at the new top. A result word
//   reaches the output register at the next word of the same character or at
//   the end of that character. Pushing a symbol with no result gives no output word.
//   Each result is held one step in a staging register so that o_last can be
//   set on the final one; the output register then parts the two channels.
//   When the receiver stalls, the sequencer holds its step until the output
//   register frees, and no new character is taken meanwhile.
//   Reset empties the stack (count to zero), holds o_ready low and drops any
//   pending words; stack memory contents are not cleared and need no clearing pass.
module infix_to_postfix_converter_top
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_symbol,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_symbol,
    output logic [1:0] o_error_code,
    output logic       o_expr_end,
    output logic       o_last
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_sym, n_sym;
    t_class        r_cls, n_cls;

    // staging register for the most recent result word
    logic          r_hvalid, n_hvalid;
    logic [7:0]    r_hsym, n_hsym;
    logic [1:0]    r_herr, n_herr;
    logic          r_hend, n_hend;

    // output register
    logic          r_ovalid;
    logic [7:0]    r_osym;
    logic [1:0]    r_oerr;
    logic          r_oend;
    logic          r_olast;

    logic [7:0]    w_top;
    logic [CW-1:0] w_cnt_dec;
    logic          w_nonempty;
    logic          w_full;
    logic          w_can_emit;
    logic          w_we;
    logic          w_oload;
    logic          w_olast;

    // action of the current evaluation step
    logic          w_em;
    logic [7:0]    w_em_sym;
    logic [1:0]    w_em_err;
    logic          w_em_end;
    logic          w_push;
    logic          w_pop;
    logic          w_clear;
    logic          w_done;
    logic          w_step_ok;

    assign w_cnt_dec  = r_count - CW'(1);
    assign w_nonempty = (r_count != '0);
    assign w_full     = (r_count == CW'(STACK_DEPTH));
    assign w_can_emit = !r_ovalid || i_ready;

    // Operator stack: read the top continuously, write on push
    i2p_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_sym),
        .i_raddr (w_cnt_dec[AW-1:0]),
        .o_rdata (w_top)
    );

    // Decide the action of one evaluation step
    always_comb begin
        w_em     = 1'b0;
        w_em_sym = C_NUL;
        w_em_err = E_NONE;
        w_em_end = 1'b0;
        w_push   = 1'b0;
        w_pop    = 1'b0;
        w_clear  = 1'b0;
        w_done   = 1'b0;
        case (r_cls)
            CL_LETTER: begin
                w_em     = 1'b1;
                w_em_sym = r_sym;
                w_done   = 1'b1;
            end
            CL_LPAREN: begin
                w_push = 1'b1;
            end
            CL_OPER: begin
                if (w_nonempty && (w_top != C_LPAR) && (f_prec(w_top) >= f_prec(r_sym))) begin
                    w_pop    = 1'b1;
                    w_em     = 1'b1;
                    w_em_sym = w_top;
                end else begin
                    w_push = 1'b1;
                end
            end
            CL_RPAREN: begin
                if (w_nonempty) begin
                    w_pop = 1'b1;
                    if (w_top == C_LPAR) begin
                        w_done = 1'b1;
                    end else begin
                        w_em     = 1'b1;
                        w_em_sym = w_top;
                    end
                end else begin
                    w_em     = 1'b1;
                    w_em_err = E_UNMATCH;
                    w_done   = 1'b1;
                end
            end
            CL_ZERO: begin
                if (w_nonempty) begin
                    w_pop    = 1'b1;
                    w_em     = (w_top != C_LPAR);
                    w_em_sym = w_top;
                end else begin
                    w_em     = 1'b1;
                    w_em_end = 1'b1;
                    w_done   = 1'b1;
                end
            end
            default: begin
                w_em     = 1'b1;
                w_em_err = E_INVALID;
                w_clear  = 1'b1;
                w_done   = 1'b1;
            end
        endcase
        // a push onto a full stack becomes an overflow word instead
        if (w_push && w_full) begin
            w_push   = 1'b0;
            w_em     = 1'b1;
            w_em_err = E_OVERFLOW;
            w_done   = 1'b1;
        end
        if (w_push) begin
            w_done = 1'b1;
        end
    end

    // A step that makes a word needs room for the staged one
    assign w_step_ok = !w_em || !r_hvalid || w_can_emit;

    assign o_ready = i_rst_n && (r_state == S_IDLE);

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_sym    = r_sym;
        n_cls    = r_cls;
        n_hvalid = r_hvalid;
        n_hsym   = r_hsym;
        n_herr   = r_herr;
        n_hend   = r_hend;
        w_we     = 1'b0;
        w_oload  = 1'b0;
        w_olast  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sym   = i_symbol;
                    n_cls   = f_class(i_symbol);
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_step_ok) begin
                    if (w_em) begin
                        w_oload  = r_hvalid;
                        n_hvalid = 1'b1;
                        n_hsym   = w_em_sym;
                        n_herr   = w_em_err;
                        n_hend   = w_em_end;
                    end
                    if (w_clear) begin
                        n_count = '0;
                    end else if (w_pop) begin
                        n_count = w_cnt_dec;
                    end else if (w_push) begin
                        w_we    = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    n_state = w_done ? S_FLUSH : S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_EVAL;
            end
            S_FLUSH: begin
                if (!r_hvalid) begin
                    n_state = S_IDLE;
                end else if (w_can_emit) begin
                    w_oload  = 1'b1;
                    w_olast  = 1'b1;
                    n_hvalid = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance control and staging registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_hvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_hvalid <= n_hvalid;
        end
        r_sym  <= n_sym;
        r_cls  <= n_cls;
        r_hsym <= n_hsym;
        r_herr <= n_herr;
        r_hend <= n_hend;
    end

    // Load the output register from staging, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oload) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (w_oload) begin
            r_osym  <= r_hsym;
            r_oerr  <= r_herr;
            r_oend  <= r_hend;
            r_olast <= w_olast;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_out_symbol = r_osym;
    assign o_error_code = r_oerr;
    assign o_expr_end   = r_oend;
    assign o_last       = r_olast;

`ifndef SYNTH
    // no staged word may be left behind when a new word is taken
    a_idle_no_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hvalid)
        else $error("staged result left over at idle");

    // the stack count never exceeds the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // a push only happens with room on the stack
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !w_full)
        else $error("push onto a full stack");

    // an accepted word is evaluated in the next cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EVAL))
        else $error("accepted word not evaluated");
`endif

endmodule
